[sv/multichannel_periodic_trigger_scheduler_defines.svh]
// Assertion helpers for the checker file.
`ifndef MULTICHANNEL_PERIODIC_TRIGGER_SCHEDULER_DEFINES_SVH
`define MULTICHANNEL_PERIODIC_TRIGGER_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define MPTS_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication.
`define MPTS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

[sv/mpts_pkg.sv]
package mpts_pkg;

    localparam int NUM_CHANNELS = 24;
    localparam int NUM_GROUPS   = 16;
    localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [3:0] OP_TICK      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_START     = 4'd2;
    localparam logic [3:0] OP_STOP     = 4'd3;
    localparam logic [3:0] OP_PAUSE     = 4'd4;
    localparam logic [3:0] OP_RESUME    = 4'd5;
    localparam logic [3:0] OP_FIRE_GRP  = 4'd6;
    localparam logic [3:0] OP_STOP_GRP  = 4'd7;
    localparam logic [3:0] OP_PAUSE_GRP = 4'd8;
    localparam logic [3:0] OP_RESUME_GRP = 4'd9;

    localparam logic REG_TICK_STEP = 1'b0;
    localparam logic REG_TIME_WRAP = 1'b1;

    localparam logic [15:0] TICK_STEP_RST = 16'd1000;
    localparam logic [31:0] TIME_WRAP_RST = 32'd1000000;

    typedef struct packed {
        logic [3:0]  op;
        logic [4:0]  channel;
        logic [3:0]  group;
        logic [31:0] period_value;
    } request_t;

    typedef struct packed {
        logic [4:0]  fired_channel;
        logic [31:0] elapsed_time;
        logic        running;
        logic        last;
    } result_t;

    // one channel's state as kept in the RAM
    typedef struct packed {
        logic [31:0] period;
        logic [31:0] count;
        logic [31:0] saved;
        logic [3:0]  group;
        logic        loaded;
    } entry_t;

    // engine to top: one fire to report
    typedef struct packed {
        logic       valid;
        logic [4:0] channel;
        logic       last;
    } emit_t;

endpackage

[sv/mpts_ram.sv]
module mpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/mpts_engine.sv]
module mpts_engine import mpts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  request_t    request,
    input  logic [15:0] tick_step,
    input  logic [31:0] time_wrap,
    output logic        busy,
    output emit_t       emit,
    output logic [31:0] elapsed_time,
    output logic        running
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CHANNELS - 1);

    logic [1:0]              state_reg, state_next;
    logic [3:0]              op_reg, op_next;
    logic [3:0]              grp_reg, grp_next;
    logic [31:0]             period_reg, period_next;
    logic [ADDR_W-1:0]       end_reg, end_next;
    logic [ADDR_W-1:0]       rd_addr_reg, rd_addr_next;
    logic                    issue_reg, issue_next;
    logic                    proc_vld_reg, proc_vld_next;
    logic [ADDR_W-1:0]       proc_addr_reg, proc_addr_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic [NUM_CHANNELS-1:0] valid_reg, valid_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [ADDR_W-1:0]       pend_ch_reg, pend_ch_next;
    logic [31:0]             tc_reg, tc_next;
    logic                    run_reg, run_next;

    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t  cur, upd;
    logic    fire, member, ram_we;
    logic    ch_ok, grp_ok, is_single, is_group;
    logic [32:0] tc_sum;
    logic [31:0] dec;

    mpts_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (proc_addr_reg),
        .wdata (upd),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign elapsed_time = tc_reg;
    assign running      = run_reg;

    assign ch_ok     = ({1'b0, request.channel} < 6'(NUM_CHANNELS));
    assign grp_ok    = ({1'b0, request.group} < 5'(NUM_GROUPS));
    assign is_single = (request.op >= OP_LOAD) && (request.op <= OP_RESUME) && ch_ok;
    assign is_group  = (request.op >= OP_FIRE_GRP) && (request.op <= OP_RESUME_GRP) && grp_ok;
    assign tc_sum    = {1'b0, tc_reg} + {17'b0, tick_step};

    // per-entry update; entries never written read as reset value
    always_comb
    begin
        cur    = rd_valid_reg ? entry_t'(ram_rdata) : '0;
        upd    = cur;
        fire   = 1'b0;
        member = cur.loaded && (cur.group == grp_reg);
        dec    = (cur.count >= {16'b0, tick_step}) ? cur.count - {16'b0, tick_step} : 32'd0;
        case (op_reg)
            OP_TICK:
            begin
                if (cur.count != 32'd0)
                begin
                    if (dec < {16'b0, tick_step})
                    begin
                        fire      = 1'b1;
                        upd.count = cur.period;
                    end
                    else
                    begin
                        upd.count = dec;
                    end
                end
            end
            OP_LOAD:
            begin
                upd.period = period_reg;
                upd.group  = grp_reg;
                upd.loaded = 1'b1;
            end
            OP_START:
            begin
                if (cur.loaded)
                begin
                    upd.count = cur.period;
                end
            end
            OP_STOP:
            begin
                upd.count = 32'd0;
            end
            OP_PAUSE:
            begin
                upd.saved = cur.count;
                upd.count = 32'd0;
            end
            OP_RESUME:
            begin
                if (cur.saved != 32'd0)
                begin
                    upd.count = cur.saved;
                    upd.saved = 32'd0;
                end
            end
            OP_FIRE_GRP:
            begin
                fire = member;
            end
            OP_STOP_GRP:
            begin
                if (member)
                begin
                    upd.count = 32'd0;
                end
            end
            OP_PAUSE_GRP:
            begin
                if (member)
                begin
                    upd.saved = cur.count;
                    upd.count = 32'd0;
                end
            end
            OP_RESUME_GRP:
            begin
                if (member && (cur.saved != 32'd0))
                begin
                    upd.count = cur.saved;
                    upd.saved = 32'd0;
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        grp_next       = grp_reg;
        period_next    = period_reg;
        end_next       = end_reg;
        rd_addr_next   = rd_addr_reg;
        issue_next     = issue_reg;
        proc_vld_next  = 1'b0;
        proc_addr_next = proc_addr_reg;
        rd_valid_next  = rd_valid_reg;
        valid_next     = valid_reg;
        pend_vld_next  = pend_vld_reg;
        pend_ch_next   = pend_ch_reg;
        tc_next        = tc_reg;
        run_next       = run_reg;
        ram_we         = 1'b0;
        emit           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = request.op;
                    grp_next    = request.group;
                    period_next = request.period_value;
                    if (request.op == OP_TICK)
                    begin
                        tc_next = (tc_sum >= {1'b0, time_wrap}) ? 32'd0 : tc_sum[31:0];
                    end
                    if ((request.op == OP_STOP_GRP) && grp_ok)
                    begin
                        run_next = 1'b0;
                    end
                    if ((request.op == OP_TICK) || is_single || is_group)
                    begin
                        state_next   = ST_SCAN;
                        issue_next   = 1'b1;
                        rd_addr_next = is_single ? request.channel[ADDR_W-1:0] : '0;
                        end_next     = is_single ? request.channel[ADDR_W-1:0] : LAST_ADDR;
                    end
                end
            end
            ST_SCAN:
            begin
                // read stage
                if (issue_reg)
                begin
                    proc_vld_next  = 1'b1;
                    proc_addr_next = rd_addr_reg;
                    rd_valid_next  = valid_reg[rd_addr_reg];
                    if (rd_addr_reg == end_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                // modify/write stage, one entry behind the read
                if (proc_vld_reg)
                begin
                    ram_we                   = 1'b1;
                    valid_next[proc_addr_reg] = 1'b1;
                    if (fire)
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            run_next = 1'b1;
                        end
                        if (pend_vld_reg)
                        begin
                            emit.valid   = 1'b1;
                            emit.channel = 5'(pend_ch_reg);
                            emit.last    = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_ch_next  = proc_addr_reg;
                    end
                    if (proc_addr_reg == end_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    emit.valid   = 1'b1;
                    emit.channel = 5'(pend_ch_reg);
                    emit.last    = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            proc_vld_reg <= 1'b0;
            valid_reg    <= '0;
            pend_vld_reg <= 1'b0;
            tc_reg       <= 32'd0;
            run_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            proc_vld_reg <= proc_vld_next;
            valid_reg    <= valid_next;
            pend_vld_reg <= pend_vld_next;
            tc_reg       <= tc_next;
            run_reg      <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        grp_reg       <= grp_next;
        period_reg    <= period_next;
        end_reg       <= end_next;
        rd_addr_reg   <= rd_addr_next;
        proc_addr_reg <= proc_addr_next;
        rd_valid_reg  <= rd_valid_next;
        pend_ch_reg   <= pend_ch_next;
    end

endmodule

[sv/multichannel_periodic_trigger_scheduler.sv]
// Multichannel periodic trigger scheduler.
// Request channel: a request is taken on a rising edge with start high and
// busy low. It carries op, channel, group and period_value (request_t).
// Result channel: each fired channel appears on result for one cycle with
// result_valid high; result.last marks the final one of a request. The
// receiver cannot hold results off, so none ever waits.
// Configuration: wr_en/wr_index/wr_data write tick_step (index 0) or
// time_wrap (index 1) in the same edge; write only while busy is low.
// Timing: channel state lives in one RAM with a registered read. A tick or
// group request walks every channel, one entry per cycle with read and
// write-back overlapped, then flushes; a single-channel request visits only
// that channel. A new request is taken only after busy drops. Invalid ops
// and out-of-range channel or group are dropped at once without going busy.
// A fire is held until the next fire of the walk or the end of the walk,
// then registered, so the last result of a request shows in the same cycle
// that busy drops.
// Reset: all channels unloaded and stopped, time counter and running flag
// zero, tick_step 1000, time_wrap 1000000. Per-entry valid bits make
// unwritten RAM entries read as zero, so no clearing pass is needed.
module multichannel_periodic_trigger_scheduler import mpts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output logic        result_valid,
    output result_t     result
);

    logic [15:0] tick_step_reg;
    logic [31:0] time_wrap_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    emit_t       emit;
    logic [31:0] elapsed_time;
    logic        running;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg <= TICK_STEP_RST;
            time_wrap_reg <= TIME_WRAP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TICK_STEP: tick_step_reg <= wr_data[15:0];
                REG_TIME_WRAP: time_wrap_reg <= wr_data;
                default:       tick_step_reg <= tick_step_reg;
            endcase
        end
    end

    mpts_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .tick_step    (tick_step_reg),
        .time_wrap    (time_wrap_reg),
        .busy         (busy),
        .emit         (emit),
        .elapsed_time (elapsed_time),
        .running      (running)
    );

    // result register: strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg.fired_channel <= emit.channel;
            result_reg.elapsed_time  <= elapsed_time;
            result_reg.running       <= running;
            result_reg.last          <= emit.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sv/mpts_checker.sv]
`include "multichannel_periodic_trigger_scheduler_defines.svh"

module mpts_checker import mpts_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_valid,
    input result_t result
);

    // more results are still coming, so the engine cannot be idle
    `MPTS_ASSERT_NOW(a_mid_busy, clk, rst_n, result_valid && !result.last, busy)

    `MPTS_ASSERT_NOW(a_ch_range, clk, rst_n, result_valid, result.fired_channel < 5'(NUM_CHANNELS))

    `MPTS_ASSERT_NEXT(a_last_gap, clk, rst_n, result_valid && result.last, !result_valid)

    // a fresh request needs a RAM read before anything can fire
    `MPTS_ASSERT_NEXT(a_no_early, clk, rst_n, start && !busy, !result_valid)

endmodule

bind multichannel_periodic_trigger_scheduler mpts_checker u_mpts_checker (.*);
